FILE: hdl/tksd_pkg.sv
`default_nettype none

package tksd_pkg;

  localparam int MaxSeqBytes = 30;
  localparam int NumWidth    = 16;

  localparam int KeyWidth  = 21;
  localparam int CoordWidth = 17;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI,
    MODE_SS3,
    MODE_UTF8
  } parse_mode_t;

  localparam logic [1:0] EV_CHAR   = 2'd0;
  localparam logic [1:0] EV_SPEC   = 2'd1;
  localparam logic [1:0] EV_MOUSE  = 2'd2;
  localparam logic [1:0] EV_RESIZE = 2'd3;

  localparam logic [4:0] K_UP    = 5'd0;
  localparam logic [4:0] K_DOWN  = 5'd1;
  localparam logic [4:0] K_RIGHT = 5'd2;
  localparam logic [4:0] K_LEFT  = 5'd3;
  localparam logic [4:0] K_HOME  = 5'd4;
  localparam logic [4:0] K_END   = 5'd5;
  localparam logic [4:0] K_INS   = 5'd6;
  localparam logic [4:0] K_DEL   = 5'd7;
  localparam logic [4:0] K_PGUP  = 5'd8;
  localparam logic [4:0] K_PGDN  = 5'd9;
  localparam logic [4:0] K_ESC   = 5'd10;
  localparam logic [4:0] K_ENTER = 5'd11;
  localparam logic [4:0] K_TAB   = 5'd12;
  localparam logic [4:0] K_BKSP  = 5'd13;
  localparam logic [4:0] K_F1    = 5'd14;
  localparam logic [4:0] K_NONE  = 5'd31;

  localparam logic [2:0] M_SHIFT = 3'd1;
  localparam logic [2:0] M_ALT   = 3'd2;
  localparam logic [2:0] M_CTRL  = 3'd4;

  localparam logic [KeyWidth-1:0] ReplChar = 21'h00FFFD;

  typedef struct packed {
    logic [1:0]            event_type;
    logic [KeyWidth-1:0]   key_code;
    logic [2:0]            modifiers;
    logic [4:0]            mouse_buttons;
    logic [CoordWidth-1:0] mouse_column;
    logic [CoordWidth-1:0] mouse_row;
  } event_t;

  function automatic logic [4:0] tilde_key(input logic [4:0] n);
    logic [4:0] k;
    case (n)
      5'd1:    k = K_HOME;
      5'd2:    k = K_INS;
      5'd3:    k = K_DEL;
      5'd4:    k = K_END;
      5'd5:    k = K_PGUP;
      5'd6:    k = K_PGDN;
      5'd11:   k = K_F1;
      5'd12:   k = K_F1 + 5'd1;
      5'd13:   k = K_F1 + 5'd2;
      5'd14:   k = K_F1 + 5'd3;
      5'd15:   k = K_F1 + 5'd4;
      5'd17:   k = K_F1 + 5'd5;
      5'd18:   k = K_F1 + 5'd6;
      5'd19:   k = K_F1 + 5'd7;
      5'd20:   k = K_F1 + 5'd8;
      5'd21:   k = K_F1 + 5'd9;
      5'd23:   k = K_F1 + 5'd10;
      5'd24:   k = K_F1 + 5'd11;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/terminal_key_sequence_decoder.sv
// Flow: an item that is accepted is held in the input register, then decoded into
// the result register once the output can advance; its event is offered from there.
// Throughput: one item per cycle while m_axis_tready does not stall the output, set
// by the single decode stage between the input and result registers; items that give no event leave no output.
// Reset: rst (synchronous) clears both valid flags and returns the parser to idle.
`default_nettype none

module terminal_key_sequence_decoder #(
  parameter int MAX_SEQ_BYTES = tksd_pkg::MaxSeqBytes,
  parameter int NUM_WIDTH     = tksd_pkg::NumWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_value
  input  wire logic [0:0]  s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // key_code[20:0], modifiers[23:21], mouse_buttons[28:24],
  // mouse_column[45:29], mouse_row[62:46], zero[63]
  output logic [63:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser    // event_type
);
  import tksd_pkg::*;

  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       out_valid;
  event_t     out_event;
  logic       advance;
  logic       step;
  logic       ev_valid;
  event_t     ev;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  tksd_parser #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES),
    .NUM_WIDTH    (NUM_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .kind      (in_kind),
    .byte_value(in_byte),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ev_valid) begin
      out_event <= ev;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event.event_type;
  assign m_axis_tdata  = {1'b0, out_event.mouse_row, out_event.mouse_column,
                          out_event.mouse_buttons, out_event.modifiers,
                          out_event.key_code};

endmodule

`default_nettype wire

FILE: hdl/tksd_parser.sv
`default_nettype none

module tksd_parser #(
  parameter int MAX_SEQ_BYTES = tksd_pkg::MaxSeqBytes,
  parameter int NUM_WIDTH     = tksd_pkg::NumWidth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            kind,
  input  wire logic [7:0]      byte_value,
  output logic                 ev_valid,
  output tksd_pkg::event_t     ev
);
  import tksd_pkg::*;

  localparam int SeqWidth = $clog2(MAX_SEQ_BYTES + 1);
  localparam int ProdWidth = NUM_WIDTH + 4;
  localparam logic [NUM_WIDTH-1:0] MaxVal = {NUM_WIDTH{1'b1}};

  parse_mode_t              mode, mode_next;
  logic [SeqWidth-1:0]      seq_len, seq_len_next;
  logic                     mouse_flag, mouse_flag_next;
  logic [1:0]               param_index, param_index_next;
  logic                     digit_seen, digit_seen_next;
  logic                     param_failed, param_failed_next;
  logic [NUM_WIDTH-1:0]     param_values [3];
  logic [NUM_WIDTH-1:0]     param_values_next [3];
  logic [1:0]               utf8_remaining, utf8_remaining_next;
  logic [1:0]               utf8_len, utf8_len_next;
  logic [KeyWidth-1:0]      utf8_acc, utf8_acc_next;

  logic [SeqWidth-1:0]      seq_inc;
  logic [NUM_WIDTH-1:0]     cur_val;
  logic [ProdWidth-1:0]     prod;
  logic [NUM_WIDTH-1:0]     digit_val;
  logic [KeyWidth-1:0]      acc_shift;
  logic                     utf8_ok;
  logic [4:0]               tilde_code;
  logic [4:0]               mouse_btns;

  assign seq_inc = seq_len + SeqWidth'(1);

  always_comb begin
    case (param_index)
      2'd0:    cur_val = param_values[0];
      2'd1:    cur_val = param_values[1];
      default: cur_val = param_values[2];
    endcase
  end

  assign prod = ({4'b0, cur_val} << 3) + ({4'b0, cur_val} << 1)
              + ProdWidth'(byte_value[3:0]);
  assign digit_val = (prod > ProdWidth'(MaxVal)) ? MaxVal : prod[NUM_WIDTH-1:0];

  assign acc_shift = {utf8_acc[KeyWidth-7:0], byte_value[5:0]};

  always_comb begin
    case (utf8_len)
      2'd0:    utf8_ok = acc_shift >= KeyWidth'(32'h80);
      2'd1:    utf8_ok = acc_shift >= KeyWidth'(32'h800)
                         && (acc_shift < KeyWidth'(32'hD800) || acc_shift > KeyWidth'(32'hDFFF));
      default: utf8_ok = acc_shift >= KeyWidth'(32'h10000)
                         && acc_shift <= KeyWidth'(32'h10FFFF);
    endcase
  end

  assign tilde_code = (param_values[0] < NUM_WIDTH'(25)) ? tilde_key(param_values[0][4:0])
                                                         : K_NONE;

  always_comb begin
    case (param_values[0][1:0])
      2'd0:    mouse_btns = 5'd1;
      2'd1:    mouse_btns = 5'd2;
      2'd2:    mouse_btns = 5'd4;
      default: mouse_btns = 5'd0;
    endcase
    if (param_values[0][6]) begin
      mouse_btns = param_values[0][0] ? 5'd16 : 5'd8;
    end
  end

  always_comb begin
    mode_next           = mode;
    seq_len_next        = seq_len;
    mouse_flag_next     = mouse_flag;
    param_index_next    = param_index;
    digit_seen_next     = digit_seen;
    param_failed_next   = param_failed;
    param_values_next   = param_values;
    utf8_remaining_next = utf8_remaining;
    utf8_len_next       = utf8_len;
    utf8_acc_next       = utf8_acc;
    ev_valid            = 1'b0;
    ev                  = '0;
    if (kind) begin
      case (mode)
        MODE_ESC: begin
          mode_next   = MODE_IDLE;
          ev_valid    = 1'b1;
          ev.event_type = EV_SPEC;
          ev.key_code = KeyWidth'(K_ESC);
        end
        MODE_CSI, MODE_SS3: mode_next = MODE_IDLE;
        default: ;
      endcase
    end else begin
      case (mode)
        MODE_ESC: begin
          if (byte_value == 8'h5B) begin
            mode_next         = MODE_CSI;
            seq_len_next      = '0;
            mouse_flag_next   = 1'b0;
            param_index_next  = 2'd0;
            digit_seen_next   = 1'b0;
            param_failed_next = 1'b0;
            param_values_next = '{default: '0};
          end else if (byte_value == 8'h4F) begin
            mode_next = MODE_SS3;
          end else begin
            mode_next     = MODE_IDLE;
            ev_valid      = 1'b1;
            ev.event_type = EV_CHAR;
            ev.key_code   = KeyWidth'(byte_value);
            ev.modifiers  = M_ALT;
          end
        end
        MODE_CSI: begin
          seq_len_next = seq_inc;
          if (byte_value inside {[8'h40:8'h7E]}) begin
            mode_next = MODE_IDLE;
            if (mouse_flag) begin
              if (!param_failed && param_index == 2'd2 && digit_seen) begin
                ev_valid         = 1'b1;
                ev.event_type    = EV_MOUSE;
                ev.mouse_buttons = mouse_btns;
                ev.modifiers     = {param_values[0][4], param_values[0][3],
                                    param_values[0][2]};
                ev.mouse_column  = CoordWidth'(param_values[1]) - CoordWidth'(1);
                ev.mouse_row     = CoordWidth'(param_values[2]) - CoordWidth'(1);
              end
            end else if (seq_inc == SeqWidth'(1)) begin
              ev.event_type = EV_SPEC;
              ev_valid      = 1'b1;
              case (byte_value)
                8'h41:   ev.key_code = KeyWidth'(K_UP);
                8'h42:   ev.key_code = KeyWidth'(K_DOWN);
                8'h43:   ev.key_code = KeyWidth'(K_RIGHT);
                8'h44:   ev.key_code = KeyWidth'(K_LEFT);
                8'h48:   ev.key_code = KeyWidth'(K_HOME);
                8'h46:   ev.key_code = KeyWidth'(K_END);
                default: ev_valid = 1'b0;
              endcase
            end else if (byte_value == 8'h7E && !param_failed && tilde_code != K_NONE) begin
              ev_valid      = 1'b1;
              ev.event_type = EV_SPEC;
              ev.key_code   = KeyWidth'(tilde_code);
            end
          end else begin
            if (byte_value == 8'h3C && seq_inc == SeqWidth'(1)) begin
              mouse_flag_next = 1'b1;
            end else if (byte_value inside {[8'h30:8'h39]}) begin
              case (param_index)
                2'd0:    param_values_next[0] = digit_val;
                2'd1:    param_values_next[1] = digit_val;
                default: param_values_next[2] = digit_val;
              endcase
              digit_seen_next = 1'b1;
            end else if (byte_value == 8'h3B) begin
              if (param_index >= 2'd2 || (mouse_flag && !digit_seen)) begin
                param_failed_next = 1'b1;
              end else begin
                param_index_next = param_index + 2'd1;
                digit_seen_next  = 1'b0;
              end
            end else begin
              param_failed_next = 1'b1;
            end
            if (seq_inc >= SeqWidth'(MAX_SEQ_BYTES)) begin
              mode_next = MODE_IDLE;
            end
          end
        end
        MODE_SS3: begin
          mode_next     = MODE_IDLE;
          ev_valid      = 1'b1;
          ev.event_type = EV_SPEC;
          case (byte_value)
            8'h50:   ev.key_code = KeyWidth'(K_F1);
            8'h51:   ev.key_code = KeyWidth'(K_F1 + 5'd1);
            8'h52:   ev.key_code = KeyWidth'(K_F1 + 5'd2);
            8'h53:   ev.key_code = KeyWidth'(K_F1 + 5'd3);
            8'h48:   ev.key_code = KeyWidth'(K_HOME);
            8'h46:   ev.key_code = KeyWidth'(K_END);
            default: ev.key_code = KeyWidth'(K_ESC);
          endcase
        end
        MODE_UTF8: begin
          ev.event_type = EV_CHAR;
          if (byte_value[7:6] != 2'b10) begin
            mode_next           = MODE_IDLE;
            utf8_remaining_next = 2'd0;
            ev_valid            = 1'b1;
            ev.key_code         = ReplChar;
          end else begin
            utf8_acc_next       = acc_shift;
            utf8_remaining_next = utf8_remaining - 2'd1;
            if (utf8_remaining == 2'd1) begin
              mode_next   = MODE_IDLE;
              ev_valid    = 1'b1;
              ev.key_code = utf8_ok ? acc_shift : ReplChar;
            end
          end
        end
        default: begin
          mode_next     = MODE_IDLE;
          ev_valid      = 1'b1;
          ev.event_type = EV_CHAR;
          if (byte_value == 8'hFF) begin
            ev.event_type = EV_RESIZE;
          end else if (byte_value == 8'h1B) begin
            mode_next = MODE_ESC;
            ev_valid  = 1'b0;
          end else if (byte_value == 8'h0D || byte_value == 8'h0A) begin
            ev.event_type = EV_SPEC;
            ev.key_code   = KeyWidth'(K_ENTER);
          end else if (byte_value == 8'h09) begin
            ev.event_type = EV_SPEC;
            ev.key_code   = KeyWidth'(K_TAB);
          end else if (byte_value == 8'h7F) begin
            ev.event_type = EV_SPEC;
            ev.key_code   = KeyWidth'(K_BKSP);
          end else if (byte_value inside {[8'h01:8'h1A]}) begin
            ev.key_code  = KeyWidth'(byte_value + 8'h60);
            ev.modifiers = M_CTRL;
          end else if (!byte_value[7]) begin
            ev.key_code = KeyWidth'(byte_value);
          end else if (byte_value inside {[8'hC2:8'hDF]}) begin
            mode_next           = MODE_UTF8;
            ev_valid            = 1'b0;
            utf8_remaining_next = 2'd1;
            utf8_len_next       = 2'd0;
            utf8_acc_next       = KeyWidth'(byte_value[4:0]);
          end else if (byte_value inside {[8'hE0:8'hEF]}) begin
            mode_next           = MODE_UTF8;
            ev_valid            = 1'b0;
            utf8_remaining_next = 2'd2;
            utf8_len_next       = 2'd1;
            utf8_acc_next       = KeyWidth'(byte_value[3:0]);
          end else if (byte_value inside {[8'hF0:8'hF4]}) begin
            mode_next           = MODE_UTF8;
            ev_valid            = 1'b0;
            utf8_remaining_next = 2'd3;
            utf8_len_next       = 2'd2;
            utf8_acc_next       = KeyWidth'(byte_value[2:0]);
          end else begin
            ev.key_code = ReplChar;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      seq_len        <= '0;
      mouse_flag     <= 1'b0;
      param_index    <= 2'd0;
      digit_seen     <= 1'b0;
      param_failed   <= 1'b0;
      param_values   <= '{default: '0};
      utf8_remaining <= 2'd0;
      utf8_len       <= 2'd0;
      utf8_acc       <= '0;
    end else if (step) begin
      mode           <= mode_next;
      seq_len        <= seq_len_next;
      mouse_flag     <= mouse_flag_next;
      param_index    <= param_index_next;
      digit_seen     <= digit_seen_next;
      param_failed   <= param_failed_next;
      param_values   <= param_values_next;
      utf8_remaining <= utf8_remaining_next;
      utf8_len       <= utf8_len_next;
      utf8_acc       <= utf8_acc_next;
    end
  end

endmodule

`default_nettype wire
